/* src/ndrm_pkg.sv */
// ----------------------------------------------------------------------------
// ndrm_pkg
// shared types and constants of the descriptor ring manager
// ----------------------------------------------------------------------------
package ndrm_pkg;

  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned TX_LEN_W    = 16;
  localparam int unsigned RX_LEN_W    = 14;

  localparam int unsigned OWN_POS     = 31;
  localparam int unsigned EOR_POS     = 30;
  localparam int unsigned FS_POS      = 29;
  localparam int unsigned LS_POS      = 28;

  localparam logic [TX_LEN_W-1:0] MAX_TX_LEN   = 16'd1518;
  localparam logic [RX_LEN_W-1:0] MAX_RX_RESET = 14'd1518;
  localparam logic [RX_LEN_W-1:0] CRC_BYTES    = 14'd4;
  localparam int unsigned         LEN_MAX      = 16383;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED  = 8'd0,
    CFG_MAX_RX   = 8'd1,
    CFG_TX_BASE  = 8'd2,
    CFG_RX_BASE  = 8'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_SEND = 1'b0,
    FUNC_RECV = 1'b1
  } func_e;

endpackage

/* src/nic_descriptor_ring_manager_core.sv */
// ----------------------------------------------------------------------------
// nic_descriptor_ring_manager_core
// transmit and receive descriptor ring bookkeeping, one result word per input
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after an input is accepted
// throughput: one word per cycle while the output is not stalled, set by the single result register
// input stalls only while the result register is full and stalled
// reset: slots, offsets and counters clear, block disabled, rx limit 1518
// ----------------------------------------------------------------------------
module nic_descriptor_ring_manager_core
  import ndrm_pkg::*;
#(
  parameter int unsigned RING_SLOTS = 64,
  parameter int unsigned SLOT_BYTES = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [TX_LEN_W-1:0]   tx_length_i,
  input  logic [WORD_W-1:0]     descriptor_status_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  accepted_o,
  output logic [IDX_W-1:0]      ring_index_o,
  output logic                  descriptor_write_enable_o,
  output logic [WORD_W-1:0]     descriptor_word_o,
  output logic [ADDR_W-1:0]     buffer_address_o,
  output logic                  doorbell_o,
  output logic [RX_LEN_W-1:0]   rx_length_o,
  output logic [CNT_W-1:0]      sent_count_o,
  output logic [CNT_W-1:0]      received_count_o,
  output logic [CNT_W-1:0]      tx_drop_count_o,
  output logic [CNT_W-1:0]      rx_drop_count_o
);

  localparam int unsigned SLOT_W     = $clog2(RING_SLOTS);
  localparam int unsigned OFF_W      = $clog2(RING_SLOTS * SLOT_BYTES);
  localparam int unsigned REARM_SIZE = (SLOT_BYTES > LEN_MAX) ? LEN_MAX : SLOT_BYTES;

  // configuration
  logic                enabled_q;
  logic [RX_LEN_W-1:0] max_rx_q;
  logic [ADDR_W-1:0]   tx_base_q, rx_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      max_rx_q  <= MAX_RX_RESET;
      tx_base_q <= '0;
      rx_base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLED: enabled_q <= cfg_data_i[0];
        CFG_MAX_RX:  max_rx_q  <= cfg_data_i[RX_LEN_W-1:0];
        CFG_TX_BASE: tx_base_q <= cfg_data_i;
        CFG_RX_BASE: rx_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rings
  logic              in_acc;
  logic              is_send, is_recv;
  logic              tx_ok, rx_ok, tx_adv, rx_adv;
  logic [SLOT_W-1:0] tx_slot, rx_slot;
  logic [OFF_W-1:0]  tx_off, rx_off;
  logic              tx_last, rx_last;

  ndrm_slot_ring #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .SLOT_W     (SLOT_W),
    .OFF_W      (OFF_W)
  ) u_tx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (tx_adv),
    .slot_o    (tx_slot),
    .offset_o  (tx_off),
    .last_o    (tx_last)
  );

  ndrm_slot_ring #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .SLOT_W     (SLOT_W),
    .OFF_W      (OFF_W)
  ) u_rx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (rx_adv),
    .slot_o    (rx_slot),
    .offset_o  (rx_off),
    .last_o    (rx_last)
  );

  // counters
  logic [CNT_W-1:0] tx_frames_q, rx_frames_q, tx_refused_q, rx_refused_q;
  logic [CNT_W-1:0] tx_frames_d, rx_frames_d, tx_refused_d, rx_refused_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic                acc_q, acc_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                we_q, we_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic                bell_q, bell_d;
  logic [RX_LEN_W-1:0] rxlen_q, rxlen_d;

  logic [RX_LEN_W-1:0] n_raw, n_strip, n_len;
  logic [31:0]         tx_slot_ext, rx_slot_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_send    = (func_i == FUNC_SEND);
  assign is_recv    = (func_i == FUNC_RECV);

  assign tx_ok = enabled_q && (tx_length_i != '0) && (tx_length_i <= MAX_TX_LEN)
                 && !descriptor_status_i[OWN_POS];
  assign rx_ok = enabled_q && !descriptor_status_i[OWN_POS];

  assign tx_adv = in_acc && is_send && tx_ok;
  assign rx_adv = in_acc && is_recv && rx_ok;

  // crc strip and frame limit
  assign n_raw   = descriptor_status_i[RX_LEN_W-1:0];
  assign n_strip = (n_raw >= CRC_BYTES) ? (n_raw - CRC_BYTES) : n_raw;
  assign n_len   = (n_strip > max_rx_q) ? '0 : n_strip;

  assign tx_slot_ext = 32'(tx_slot);
  assign rx_slot_ext = 32'(rx_slot);

  always_comb begin
    tx_frames_d  = tx_frames_q;
    rx_frames_d  = rx_frames_q;
    tx_refused_d = tx_refused_q;
    rx_refused_d = rx_refused_q;
    acc_d   = 1'b0;
    we_d    = 1'b0;
    word_d  = '0;
    addr_d  = '0;
    bell_d  = 1'b0;
    rxlen_d = '0;
    if (is_send) begin
      idx_d = tx_slot_ext[IDX_W-1:0];
      if (tx_ok) begin
        acc_d  = 1'b1;
        we_d   = 1'b1;
        bell_d = 1'b1;
        word_d = WORD_W'(tx_length_i);
        word_d[OWN_POS] = 1'b1;
        word_d[FS_POS]  = 1'b1;
        word_d[LS_POS]  = 1'b1;
        word_d[EOR_POS] = tx_last;
        addr_d = tx_base_q + ADDR_W'(tx_off);
        tx_frames_d = tx_frames_q + CNT_W'(1);
      end else begin
        tx_refused_d = tx_refused_q + CNT_W'(1);
      end
    end else begin
      idx_d = rx_slot_ext[IDX_W-1:0];
      if (rx_ok) begin
        we_d    = 1'b1;
        rxlen_d = n_len;
        word_d  = WORD_W'(REARM_SIZE);
        word_d[OWN_POS] = 1'b1;
        word_d[EOR_POS] = rx_last;
        addr_d = rx_base_q + ADDR_W'(rx_off);
        if (n_len != '0) begin
          acc_d       = 1'b1;
          rx_frames_d = rx_frames_q + CNT_W'(1);
        end else begin
          rx_refused_d = rx_refused_q + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      tx_frames_q  <= '0;
      rx_frames_q  <= '0;
      tx_refused_q <= '0;
      rx_refused_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        tx_frames_q  <= tx_frames_d;
        rx_frames_q  <= rx_frames_d;
        tx_refused_q <= tx_refused_d;
        rx_refused_q <= rx_refused_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q   <= acc_d;
      idx_q   <= idx_d;
      we_q    <= we_d;
      word_q  <= word_d;
      addr_q  <= addr_d;
      bell_q  <= bell_d;
      rxlen_q <= rxlen_d;
    end
  end

  assign out_valid_o               = out_valid_q;
  assign accepted_o                = acc_q;
  assign ring_index_o              = idx_q;
  assign descriptor_write_enable_o = we_q;
  assign descriptor_word_o         = word_q;
  assign buffer_address_o          = addr_q;
  assign doorbell_o                = bell_q;
  assign rx_length_o               = rxlen_q;
  assign sent_count_o              = tx_frames_q;
  assign received_count_o          = rx_frames_q;
  assign tx_drop_count_o           = tx_refused_q;
  assign rx_drop_count_o           = rx_refused_q;

  // checks
  a_bell_implies_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bell_q |-> acc_q && we_q)
    else $error("doorbell without queued descriptor write");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !we_q |-> word_q == '0 && addr_q == '0)
    else $error("descriptor word or address set without write enable");

  a_rxlen_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rxlen_q != '0 |-> acc_q && we_q)
    else $error("received length reported without accepted frame");

  a_tx_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_adv |=> tx_frames_q == $past(tx_frames_q) + CNT_W'(1))
    else $error("sent count did not advance with transmit slot");

endmodule

/* src/ndrm_slot_ring.sv */
// ----------------------------------------------------------------------------
// ndrm_slot_ring
// slot pointer of one descriptor ring with its running buffer offset
// ----------------------------------------------------------------------------
module ndrm_slot_ring #(
  parameter int unsigned RING_SLOTS = 64,
  parameter int unsigned SLOT_BYTES = 2048,
  parameter int unsigned SLOT_W     = $clog2(RING_SLOTS),
  parameter int unsigned OFF_W      = $clog2(RING_SLOTS * SLOT_BYTES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic [OFF_W-1:0]  offset_o,
  output logic              last_o
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);
  localparam logic [OFF_W-1:0]  STEP      = OFF_W'(SLOT_BYTES);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [OFF_W-1:0]  off_q, off_d;

  assign last_o = (slot_q == LAST_SLOT);

  always_comb begin
    slot_d = slot_q;
    off_d  = off_q;
    if (advance_i) begin
      if (last_o) begin
        slot_d = '0;
        off_d  = '0;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
        off_d  = off_q + STEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      off_q  <= '0;
    end else begin
      slot_q <= slot_d;
      off_q  <= off_d;
    end
  end

  assign slot_o   = slot_q;
  assign offset_o = off_q;

endmodule
